FILE: rtl/swnp_pkg.sv
// Shared types and constants for the sliding-window predictor.
package swnp_pkg;

  localparam int unsigned WINDOW_POINTS = 5;
  localparam int unsigned CHANNELS      = 6;
  localparam int unsigned PT_W          = $clog2(WINDOW_POINTS + 1);
  localparam int unsigned IDX_W         = $clog2(WINDOW_POINTS);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTFULL = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [63:0] SAT64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // One Neville step request shared by all lanes
  typedef struct packed {
    logic        start;
    logic [33:0] a;   // r - r_{i+m}, signed 34 bits
    logic [33:0] b;   // r - r_i
    logic [33:0] d;   // r_i - r_{i+m}
  } step_cmd_t;

  typedef struct packed {
    logic       start;
    logic       busy;
  } lane_stat_t;

endpackage

FILE: rtl/swnp_if.sv
// Valid/ready channel interfaces for input and result items.
interface swnp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] time_us;
  logic signed [31:0] force_x_in;
  logic signed [31:0] force_y_in;
  logic signed [31:0] force_z_in;
  logic signed [31:0] torque_x_in;
  logic signed [31:0] torque_y_in;
  logic signed [31:0] torque_z_in;
  modport source (output valid, func, time_us, force_x_in, force_y_in, force_z_in,
                  torque_x_in, torque_y_in, torque_z_in, input ready);
  modport sink (input valid, func, time_us, force_x_in, force_y_in, force_z_in,
                torque_x_in, torque_y_in, torque_z_in, output ready);
endinterface

interface swnp_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] force_x_est;
  logic signed [31:0] force_y_est;
  logic signed [31:0] force_z_est;
  logic signed [31:0] torque_x_est;
  logic signed [31:0] torque_y_est;
  logic signed [31:0] torque_z_est;
  logic [1:0]  status;
  modport source (output valid, force_x_est, force_y_est, force_z_est, torque_x_est,
                  torque_y_est, torque_z_est, status, input ready);
  modport sink (input valid, force_x_est, force_y_est, force_z_est, torque_x_est,
                torque_y_est, torque_z_est, status, output ready);
endinterface

FILE: rtl/swnp_lane.sv
// One channel lane: Neville step unit with multi-cycle products and restoring divide.
module swnp_lane
  import swnp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  step_cmd_t          cmd,
  input  logic signed [63:0] p_in,
  input  logic signed [63:0] q_in,
  output logic signed [63:0] res,
  output lane_stat_t         stat
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lst_t;

  lst_t         st_r, st_nxt;
  logic [63:0]  am_r, pm_r, bm_r, qm_r;
  logic [63:0]  dm_r;
  logic         n1_r, n2_r, dneg_r;
  logic [1:0]   ph_r;
  logic [127:0] m1_r, m2_r;
  logic [127:0] num_r;
  logic [64:0]  rem_r;
  logic [127:0] quo_r;
  logic [6:0]   cnt_r;
  logic         neg_r;
  logic signed [63:0] res_r;

  logic [33:0]  pa;
  logic [31:0]  pb;
  logic [65:0]  pp;
  logic [127:0] sum_w, num_w;
  logic         neg_w;
  logic [64:0]  rsh;
  logic [63:0]  qres;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : v;
  endfunction

  // Pick one 34x32 partial product per cycle; step magnitudes fit in 34 bits
  always_comb begin
    case (ph_r)
      2'd0:    begin pa = am_r[33:0]; pb = pm_r[31:0];  end
      2'd1:    begin pa = am_r[33:0]; pb = pm_r[63:32]; end
      2'd2:    begin pa = bm_r[33:0]; pb = qm_r[31:0];  end
      default: begin pa = bm_r[33:0]; pb = qm_r[63:32]; end
    endcase
    pp = 66'(pa) * 66'(pb);
  end

  // Combine magnitudes with signs and add half the divisor for rounding
  always_comb begin
    if (n1_r == n2_r) begin
      sum_w = m1_r + m2_r; neg_w = n1_r;
    end else if (m1_r >= m2_r) begin
      sum_w = m1_r - m2_r; neg_w = n1_r;
    end else begin
      sum_w = m2_r - m1_r; neg_w = n2_r;
    end
    num_w = sum_w + {65'd0, dm_r[63:1]};
  end

  assign rsh  = {rem_r[63:0], num_r[127]};
  assign qres = (quo_r[127:64] != 64'd0 || quo_r[63:0] > SAT64) ? SAT64 : quo_r[63:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE: if (cmd.start) st_nxt = L_MUL;
      L_MUL:  if (ph_r == 2'd3) st_nxt = L_DIV;
      L_DIV:  if (cnt_r == 7'd0) st_nxt = L_DONE;
      L_DONE: st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= L_IDLE;
    else st_r <= st_nxt;
  end

  // Datapath: load operands, accumulate products, shift-subtract divide, then sign and saturate the quotient
  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: if (cmd.start) begin
        am_r <= mag(64'(signed'(cmd.a)));
        bm_r <= mag(64'(signed'(cmd.b)));
        dm_r <= mag(64'(signed'(cmd.d)));
        pm_r <= mag(p_in);
        qm_r <= mag(q_in);
        n1_r <= cmd.a[33] != p_in[63];
        n2_r <= !(cmd.b[33] != q_in[63]);
        dneg_r <= cmd.d[33];
        ph_r <= 2'd0;
        m1_r <= '0;
        m2_r <= '0;
      end
      L_MUL: begin
        case (ph_r)
          2'd0:    m1_r <= m1_r + {62'd0, pp};
          2'd1:    m1_r <= m1_r + {30'd0, pp, 32'd0};
          2'd2:    m2_r <= m2_r + {62'd0, pp};
          default: m2_r <= m2_r + {30'd0, pp, 32'd0};
        endcase
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) cnt_r <= 7'd127;
        rem_r <= '0;
        quo_r <= '0;
      end
      L_DIV: begin
        // first cycle latches the rounded numerator
        if (rem_r == '0 && quo_r == '0 && cnt_r == 7'd127) begin
          num_r <= num_w << 1;
          neg_r <= neg_w != dneg_r;
          rem_r <= ({64'd0, num_w[127]} >= {1'b0, dm_r}) ? 65'({64'd0, num_w[127]} - {1'b0, dm_r})
                                                         : {64'd0, num_w[127]};
          quo_r <= {127'd0, ({64'd0, num_w[127]} >= {1'b0, dm_r})};
        end else begin
          num_r <= num_r << 1;
          rem_r <= (rsh >= {1'b0, dm_r}) ? 65'(rsh - {1'b0, dm_r}) : rsh;
          quo_r <= {quo_r[126:0], (rsh >= {1'b0, dm_r})};
        end
        cnt_r <= cnt_r - 7'd1;
      end
      L_DONE: begin
        if (dm_r == 64'd0) res_r <= '0;
        else res_r <= neg_r ? 64'(-qres) : qres;
      end
      default: ;
    endcase
  end

  assign res         = res_r;
  assign stat.start  = cmd.start;
  assign stat.busy   = (st_r != L_IDLE);

endmodule

FILE: rtl/sliding_window_newton_predictor.sv
// Top level: sample window, Neville sequencer, six lanes and result register.
//
// A push shifts the window and appends the sample. A query with a full,
// distinct window runs the ten Neville steps of a five-point recurrence one
// after another; for each step the sequencer issues the shared command, the
// lanes form their products, divide with rounding and saturate, the sequencer
// waits for lane 0 to go idle and writes the results back. Each lane divides
// with a 128-bit restoring divider. All six channels run in parallel lanes. A
// query on a short window or with repeated stamps skips the steps and goes
// straight to the output state. A waiting result stays in the output register
// while further items are taken; a finished query waits for that register to be free.
module sliding_window_newton_predictor
  import swnp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  swnp_in_if.sink    in_ch,
  swnp_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DONE  = 5'b01000,
    S_OUT   = 5'b10000
  } st_t;

  st_t st_r, st_nxt;
  logic [31:0] wt_r [WINDOW_POINTS];
  logic signed [31:0] wv_r [WINDOW_POINTS][CHANNELS];
  logic [PT_W-1:0] fill_r;
  logic signed [63:0] pv_r [CHANNELS][WINDOW_POINTS];
  logic [IDX_W-1:0] m_r, i_r;
  logic [31:0] rq_r;
  logic signed [31:0] est_r [CHANNELS];
  logic [1:0] status_r;
  logic [1:0] qstat_r;
  logic valid_r;
  logic issued_r;

  step_cmd_t  cmd;
  logic signed [63:0] lres [CHANNELS];
  lane_stat_t lstat [CHANNELS];
  logic dup;
  logic out_free;
  logic [31:0] ri, rim;
  logic signed [31:0] din [CHANNELS];

  assign din[0] = in_ch.force_x_in;
  assign din[1] = in_ch.force_y_in;
  assign din[2] = in_ch.force_z_in;
  assign din[3] = in_ch.torque_x_in;
  assign din[4] = in_ch.torque_y_in;
  assign din[5] = in_ch.torque_z_in;

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_free    = !valid_r || out_ch.ready;

  // Detect any repeated stamp in the window
  always_comb begin
    dup = 1'b0;
    for (int a = 0; a < WINDOW_POINTS; a++)
      for (int b = a + 1; b < WINDOW_POINTS; b++)
        if (wt_r[a] == wt_r[b]) dup = 1'b1;
  end

  // Build the step operands from relative times
  always_comb begin
    ri  = wt_r[i_r] - wt_r[0];
    rim = wt_r[IDX_W'(32'(i_r) + 32'(m_r))] - wt_r[0];
    cmd.start = (st_r == S_ISSUE);
    cmd.a = 34'({2'b00, rq_r}) - 34'({2'b00, rim});
    cmd.b = 34'({2'b00, rq_r}) - 34'({2'b00, ri});
    cmd.d = 34'({2'b00, ri}) - 34'({2'b00, rim});
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    swnp_lane u_lane (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .p_in(pv_r[c][i_r]), .q_in(pv_r[c][IDX_W'(32'(i_r) + 1)]),
      .res(lres[c]), .stat(lstat[c])
    );
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_ch.valid && in_ch.ready && in_ch.func == FUNC_QUERY) begin
        if (fill_r < PT_W'(WINDOW_POINTS) || dup) st_nxt = S_OUT;
        else st_nxt = S_ISSUE;
      end
      S_ISSUE: st_nxt = S_WAIT;
      S_WAIT:  if (!lstat[0].busy && issued_r) st_nxt = S_DONE;
      S_DONE:  if (32'(m_r) == WINDOW_POINTS - 1 && 32'(i_r) == 0) st_nxt = S_OUT;
               else st_nxt = S_ISSUE;
      S_OUT:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      fill_r <= '0;
      valid_r <= 1'b0;
      issued_r <= 1'b0;
      for (int p = 0; p < WINDOW_POINTS; p++) begin
        wt_r[p] <= '0;
        for (int c = 0; c < CHANNELS; c++) wv_r[p][c] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      // Raise a result once the output register is free, drop it once taken
      if (st_r == S_OUT && out_free) valid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          if (in_ch.func == FUNC_PUSH) begin
            // shift window, append sample
            for (int p = 0; p + 1 < WINDOW_POINTS; p++) begin
              wt_r[p] <= wt_r[p+1];
              for (int c = 0; c < CHANNELS; c++) wv_r[p][c] <= wv_r[p+1][c];
            end
            wt_r[WINDOW_POINTS-1] <= in_ch.time_us;
            for (int c = 0; c < CHANNELS; c++) wv_r[WINDOW_POINTS-1][c] <= din[c];
            if (fill_r < PT_W'(WINDOW_POINTS)) fill_r <= fill_r + 1'b1;
          end else begin
            qstat_r <= (fill_r < PT_W'(WINDOW_POINTS)) ? ST_NOTFULL :
                       (dup ? ST_DUP : ST_OK);
            rq_r <= in_ch.time_us - wt_r[0];
            m_r <= IDX_W'(1);
            i_r <= '0;
            for (int c = 0; c < CHANNELS; c++)
              for (int p = 0; p < WINDOW_POINTS; p++) pv_r[c][p] <= 64'(wv_r[p][c]);
          end
        end
        S_ISSUE: issued_r <= 1'b0;
        S_WAIT: if (lstat[0].busy) issued_r <= 1'b1;
        S_DONE: begin
          for (int c = 0; c < CHANNELS; c++) pv_r[c][i_r] <= lres[c];
          if (32'(i_r) + 32'(m_r) + 1 < WINDOW_POINTS) i_r <= i_r + 1'b1;
          else begin
            i_r <= '0;
            m_r <= m_r + 1'b1;
          end
        end
        S_OUT: if (out_free) begin
          status_r <= qstat_r;
          for (int c = 0; c < CHANNELS; c++)
            est_r[c] <= (qstat_r != ST_OK) ? 32'sd0 :
                        (pv_r[c][0] > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (pv_r[c][0] < -64'sh8000_0000) ? 32'sh8000_0000 :
                        pv_r[c][0][31:0];
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.force_x_est  = est_r[0];
  assign out_ch.force_y_est  = est_r[1];
  assign out_ch.force_z_est  = est_r[2];
  assign out_ch.torque_x_est = est_r[3];
  assign out_ch.torque_y_est = est_r[4];
  assign out_ch.torque_z_est = est_r[5];
  assign out_ch.status       = status_r;

endmodule

FILE: rtl/swnp_checker.sv
// Port-level checks on the predictor, bound to the top level.
module swnp_checker
  import swnp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [31:0] out_fx
);

  // a held result keeps its status
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // status never takes the unused code
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");

  // flagged results carry a zero force_x estimate
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_fx == 32'd0) else $error("nonzero on error");

  // a push never raises a result next cycle
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_PUSH && !out_valid |=> !out_valid)
    else $error("push produced result");

endmodule

bind sliding_window_newton_predictor swnp_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.func),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_fx(out_ch.force_x_est)
);

FILE: tb/swnp_tb_if.sv
// Interfaces are supplied by the RTL; this file holds testbench-side item types.
`timescale 1ns / 1ps
package swnp_tb_pkg;
  typedef struct {
    logic        func;
    logic [31:0] time_us;
    logic signed [31:0] smp [6];
  } sample_item_t;

  typedef struct {
    logic signed [31:0] est [6];
    logic [1:0]         status;
  } estimate_t;
endpackage

FILE: tb/sliding_window_newton_predictor_tb.sv
// Testbench for the sliding-window predictor: directed and random pushes and queries.
`timescale 1ns / 1ps
module sliding_window_newton_predictor_tb;
  import swnp_pkg::*;
  import swnp_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   idle_cycles = 0;
  int   stall_left = 0;
  int   queries_sent;
  int   pushes_sent;
  int   results_seen;
  bit   out_stalls;
  bit   in_gaps;
  bit   timed_out;

  string est_name [6] = '{"force_x_est", "force_y_est", "force_z_est",
                          "torque_x_est", "torque_y_est", "torque_z_est"};

  swnp_in_if  in_ch ();
  swnp_out_if out_ch ();

  sliding_window_newton_predictor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Predictor state
  logic [31:0]        win_stamp [WINDOW_POINTS];
  logic signed [63:0] win_val [WINDOW_POINTS][CHANNELS];
  int                 win_fill;
  estimate_t          pending_est [$];

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Rounded, saturated (a*p - b*q) / d, exact in wide signed arithmetic
  function automatic logic signed [63:0] neville_term(logic signed [63:0] a,
      logic signed [63:0] p, logic signed [63:0] b, logic signed [63:0] q,
      logic signed [63:0] d);
    logic signed [131:0] num;
    logic signed [131:0] dn;
    logic [131:0]        mag;
    logic [131:0]        dm;
    logic [131:0]        quo;
    bit                  neg;
    if (d == 0) return 64'sd0;
    num = 132'(a) * 132'(p) - 132'(b) * 132'(q);
    dn  = 132'(d);
    neg = (num < 0) != (dn < 0);
    mag = num < 0 ? -num : num;
    dm  = dn < 0 ? -dn : dn;
    quo = (mag + (dm >> 1)) / dm;
    if (quo > 132'(SAT64)) quo = 132'(SAT64);
    return neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
  endfunction

  function automatic logic signed [31:0] interpolate(int ch, logic [31:0] rq);
    logic signed [63:0] rel [WINDOW_POINTS];
    logic signed [63:0] pv [WINDOW_POINTS];
    logic signed [63:0] r;
    r = {32'd0, rq};
    for (int i = 0; i < WINDOW_POINTS; i++) begin
      rel[i] = {32'd0, 32'(win_stamp[i] - win_stamp[0])};
      pv[i]  = win_val[i][ch];
    end
    for (int m = 1; m < WINDOW_POINTS; m++)
      for (int i = 0; i + m < WINDOW_POINTS; i++)
        pv[i] = neville_term(r - rel[i+m], pv[i], r - rel[i], pv[i+1], rel[i] - rel[i+m]);
    if (pv[0] > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (pv[0] < -64'sh8000_0000) return 32'sh8000_0000;
    return pv[0][31:0];
  endfunction

  // Advance the predictor by one accepted item
  task automatic predict_item(sample_item_t it);
    estimate_t e;
    if (it.func == FUNC_PUSH) begin
      for (int i = 0; i + 1 < WINDOW_POINTS; i++) begin
        win_stamp[i] = win_stamp[i+1];
        win_val[i]   = win_val[i+1];
      end
      win_stamp[WINDOW_POINTS-1] = it.time_us;
      for (int c = 0; c < CHANNELS; c++) win_val[WINDOW_POINTS-1][c] = 64'(it.smp[c]);
      if (win_fill < WINDOW_POINTS) win_fill++;
      pushes_sent++;
      return;
    end
    e.status = ST_OK;
    if (win_fill < WINDOW_POINTS) e.status = ST_NOTFULL;
    else
      for (int i = 0; i < WINDOW_POINTS; i++)
        for (int j = i + 1; j < WINDOW_POINTS; j++)
          if (win_stamp[i] == win_stamp[j]) e.status = ST_DUP;
    for (int c = 0; c < CHANNELS; c++)
      e.est[c] = (e.status == ST_OK) ? interpolate(c, it.time_us - win_stamp[0]) : 32'sd0;
    pending_est.push_back(e);
    queries_sent++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 30);
  endfunction

  // Send one item and wait for it to be accepted; valid drops only across a gap
  task automatic send_item(sample_item_t it);
    int gap;
    gap = in_gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= it.func;
    in_ch.time_us     <= it.time_us;
    in_ch.force_x_in  <= it.smp[0];
    in_ch.force_y_in  <= it.smp[1];
    in_ch.force_z_in  <= it.smp[2];
    in_ch.torque_x_in <= it.smp[3];
    in_ch.torque_y_in <= it.smp[4];
    in_ch.torque_z_in <= it.smp[5];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(it);
  endtask

  function automatic logic signed [31:0] rand_value(int kind);
    case (kind)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(0, 65535)) << 8) - 32'sh0080_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic push_sample(logic [31:0] stamp, int kind);
    sample_item_t it;
    it.func    = FUNC_PUSH;
    it.time_us = stamp;
    for (int c = 0; c < CHANNELS; c++) it.smp[c] = rand_value(kind);
    send_item(it);
  endtask

  task automatic query_at(logic [31:0] stamp);
    sample_item_t it;
    it.func    = FUNC_QUERY;
    it.time_us = stamp;
    for (int c = 0; c < CHANNELS; c++) it.smp[c] = $signed($urandom());
    send_item(it);
  endtask

  // Directed: short window, extremes, duplicates, wrapped and far query times
  task automatic test_directed();
    query_at(32'd0);
    push_sample(32'd100, 0);
    query_at(32'd150);
    push_sample(32'd200, 1);
    push_sample(32'd300, 0);
    push_sample(32'd400, 1);
    query_at(32'd450);
    push_sample(32'd500, 0);
    query_at(32'd250);
    query_at(32'd50);
    query_at(32'hFFFF_FFFF);
    query_at(32'd500);
    push_sample(32'd500, 3);
    query_at(32'd510);
    for (int i = 0; i < 5; i++) push_sample(32'hFFFF_FFF0 + 32'(i * 8), 2);
    query_at(32'h0000_0010);
    query_at(32'hFFFF_FFF4);
    for (int i = 0; i < 5; i++) push_sample(32'(i * 3) + 32'h8000_0000, 3);
    query_at(32'h8000_0005);
    query_at(32'h7FFF_FFFF);
  endtask

  // Random: mostly rising stamp sequences with a few duplicates and junk stamps
  task automatic test_random(int n_items);
    logic [31:0] stamp;
    stamp = $urandom();
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: query_at($urandom());
          1: query_at(win_stamp[0] - 32'($urandom_range(1, 20)));
          default: query_at(win_stamp[0] + 32'($urandom_range(0, 4 * 64)));
        endcase
      end else begin
        case ($urandom_range(0, 19))
          0: stamp = $urandom();
          1: ;
          default: stamp += 32'($urandom_range(1, 64));
        endcase
        push_sample(stamp, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1)
                                                     : $urandom_range(2, 3));
      end
      if (k == n_items / 2) in_gaps = 1'b0;
      if (k == 3 * n_items / 4) in_gaps = 1'b1;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_est.size() != 0 && !timed_out) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  // Result checker and sink stalls
  always @(posedge clk) begin
    estimate_t e;
    logic signed [31:0] got [6];
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = '{out_ch.force_x_est, out_ch.force_y_est, out_ch.force_z_est,
                out_ch.torque_x_est, out_ch.torque_y_est, out_ch.torque_z_est};
        if (pending_est.size() == 0) begin
          $error("unexpected result item");
          fail_count++;
        end else begin
          e = pending_est.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_ch.status);
            fail_count++;
          end
          for (int c = 0; c < CHANNELS; c++)
            if (got[c] !== e.est[c]) begin
              $error("%s: expected %0d, actual %0d", est_name[c], e.est[c], got[c]);
              fail_count++;
            end
        end
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (out_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= gap_len();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fail_count   = 0;
    queries_sent = 0;
    pushes_sent  = 0;
    results_seen = 0;
    timed_out    = 1'b0;
    out_stalls   = 1'b1;
    in_gaps      = 1'b1;
    win_fill     = 0;
    for (int i = 0; i < WINDOW_POINTS; i++) begin
      win_stamp[i] = '0;
      for (int c = 0; c < CHANNELS; c++) win_val[i][c] = '0;
    end
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_PUSH;
    in_ch.time_us     = '0;
    in_ch.force_x_in  = '0;
    in_ch.force_y_in  = '0;
    in_ch.force_z_in  = '0;
    in_ch.torque_x_in = '0;
    in_ch.torque_y_in = '0;
    in_ch.torque_z_in = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1000);
    out_stalls = 1'b0;
    test_random(580);
    drain();
    if (pending_est.size() != 0) begin
      $error("%0d expected results never arrived", pending_est.size());
      fail_count++;
    end
    $display("Covered %0d pushes and %0d queries; %0d results checked.",
             pushes_sent, queries_sent, results_seen);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: sliding_window_newton_predictor.f
rtl/swnp_pkg.sv
rtl/swnp_if.sv
rtl/swnp_lane.sv
rtl/sliding_window_newton_predictor.sv
rtl/swnp_checker.sv
tb/swnp_tb_if.sv
tb/sliding_window_newton_predictor_tb.sv
